// File: rtl/pasf_pkg.sv
package pasf_pkg;

    // coordinate and accumulator widths
    localparam int COORD_BITS    = 16;
    localparam int ACC_FRAC      = 16;
    localparam int XW            = COORD_BITS + ACC_FRAC + 3;
    localparam int ZW            = 24;
    localparam int ACCW          = ZW + 2;
    localparam int CORDIC_ITERS  = 20;
    localparam int SECTOR_SLOTS  = 3;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_0   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE  = 3'd6;

    // angle constants in degrees
    localparam int DEG90  = 90;
    localparam int DEG180 = 180;
    localparam int DEG270 = 270;
    localparam int DEG360 = 360;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
        logic        [2:0]            channel_tag;
        logic                         cloud_last;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic        [2:0]            out_channel;
        logic                         keep;
        logic                         out_last;
    } t_point_out;

    // rotation state carried down the cell chain
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 base_180;
        logic                 origin;
        t_point_in            pt;
    } t_cordic;

    // sector bounds and enables seen by the output stage
    typedef struct packed {
        logic [SECTOR_SLOTS-1:0][CFG_DATA_BITS-1:0] lo_b;
        logic [SECTOR_SLOTS-1:0][CFG_DATA_BITS-1:0] hi_b;
        logic [SECTOR_SLOTS-1:0]                    enable;
    } t_sector_cfg;

    // atan(2^-i) in degrees, 16 fraction bits, rounded
    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                0:       v = 24'sd2949120;
                1:       v = 24'sd1740967;
                2:       v = 24'sd919879;
                3:       v = 24'sd466945;
                4:       v = 24'sd234379;
                5:       v = 24'sd117304;
                6:       v = 24'sd58666;
                7:       v = 24'sd29335;
                8:       v = 24'sd14668;
                9:       v = 24'sd7334;
                10:      v = 24'sd3667;
                11:      v = 24'sd1833;
                12:      v = 24'sd917;
                13:      v = 24'sd458;
                14:      v = 24'sd229;
                15:      v = 24'sd115;
                16:      v = 24'sd57;
                17:      v = 24'sd29;
                18:      v = 24'sd14;
                19:      v = 24'sd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/pasf_prep.sv
module pasf_prep
    import pasf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_point_in i_pt,
    output logic      o_valid,
    input  logic      i_ready,
    output t_cordic   o_cell
);

    logic    r_valid;
    t_cordic r_cell;
    t_cordic n_cell;
    logic    advance;
    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    // scale to accumulator units, fold left half plane onto right
    always_comb begin
        x_ext = XW'(i_pt.x_coord) <<< ACC_FRAC;
        y_ext = XW'(i_pt.y_coord) <<< ACC_FRAC;
        n_cell.pt       = i_pt;
        n_cell.z        = '0;
        n_cell.origin   = (i_pt.x_coord == '0) && (i_pt.y_coord == '0);
        n_cell.base_180 = i_pt.x_coord[COORD_BITS-1];
        if (i_pt.x_coord[COORD_BITS-1]) begin
            n_cell.x = -x_ext;
            n_cell.y = -y_ext;
        end else begin
            n_cell.x = x_ext;
            n_cell.y = y_ext;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    // word register
    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: rtl/pasf_cell.sv
module pasf_cell
    import pasf_pkg::*;
#(
    parameter int STEP = 0
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cordic i_cell,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cordic o_cell
);

    localparam logic signed [ZW-1:0] ANGLE = atan_step(STEP);

    logic    r_valid;
    t_cordic r_cell;
    t_cordic n_cell;
    logic    advance;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    // one vectoring micro-rotation, driving y toward zero
    always_comb begin
        dx     = i_cell.y >>> STEP;
        dy     = i_cell.x >>> STEP;
        n_cell = i_cell;
        if (!i_cell.y[XW-1]) begin
            n_cell.x = i_cell.x + dx;
            n_cell.y = i_cell.y - dy;
            n_cell.z = i_cell.z + ANGLE;
        end else begin
            n_cell.x = i_cell.x - dx;
            n_cell.y = i_cell.y + dy;
            n_cell.z = i_cell.z - ANGLE;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    // word register
    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: rtl/pasf_sector.sv
module pasf_sector
    import pasf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cordic     i_cell,
    input  t_sector_cfg i_cfg,
    output logic        o_valid,
    input  logic        i_stall,
    output t_point_out  o_word
);

    localparam int BW = 9 + ANGLE_FRAC_BITS;
    localparam int CW = (BW > CFG_DATA_BITS) ? BW : CFG_DATA_BITS;
    localparam logic signed [ACCW-1:0] OFS_90  = ACCW'(DEG90 * (2 ** ACC_FRAC));
    localparam logic signed [ACCW-1:0] OFS_180 = ACCW'(DEG180 * (2 ** ACC_FRAC));
    localparam logic signed [ACCW-1:0] OFS_360 = ACCW'(DEG360 * (2 ** ACC_FRAC));
    localparam logic [BW-1:0] ORIGIN_BEARING = BW'(DEG270) << ANGLE_FRAC_BITS;

    logic       r_valid;
    t_point_out r_word;
    t_point_out n_word;
    logic       advance;
    logic signed [ACCW-1:0] acc;
    logic signed [ACCW-1:0] acc_wrap;
    logic [BW-1:0] bearing;
    logic [CW-1:0] bearing_cmp;
    logic [SECTOR_SLOTS-1:0] hit;

    assign advance = !r_valid || !i_stall;
    assign o_ready = advance;

    // bearing: base + angle - 90 deg, wrapped into one turn
    always_comb begin
        acc = ACCW'(i_cell.z) - OFS_90;
        if (i_cell.base_180) begin
            acc = acc + OFS_180;
        end
        acc_wrap = acc[ACCW-1] ? (acc + OFS_360) : acc;
        if (i_cell.origin) begin
            bearing = ORIGIN_BEARING;
        end else begin
            bearing = acc_wrap[ACC_FRAC+8:ACC_FRAC-ANGLE_FRAC_BITS];
        end
        bearing_cmp = CW'(bearing);
    end

    // inclusive sector match
    always_comb begin
        for (int s = 0; s < SECTOR_SLOTS; s++) begin
            hit[s] = i_cfg.enable[s]
                  && (bearing_cmp >= CW'(i_cfg.lo_b[s]))
                  && (bearing_cmp <= CW'(i_cfg.hi_b[s]));
        end
        n_word.out_x       = i_cell.pt.x_coord;
        n_word.out_y       = i_cell.pt.y_coord;
        n_word.out_z       = i_cell.pt.z_coord;
        n_word.out_channel = i_cell.pt.channel_tag;
        n_word.keep        = ~|hit;
        n_word.out_last    = i_cell.pt.cloud_last;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/point_angle_sector_filter_core.sv
// channel   direction  handshake                       payload
// in        input      i_in_valid / o_in_stall         i_in_word  (t_point_in)
// out       output     o_out_valid / i_out_stall       o_out_word (t_point_out)
// cfg       input      i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one word per cycle in and out while i_out_stall is low. stages: one folding
// stage, one cell per cordic micro-rotation (20), one bearing/compare stage.
// each stage holds a word while the next is full, so bubbles close up and
// a stall at the output fills the chain before o_in_stall rises.
// reset clears all stage valid flags and the sector registers.
// the config port is always ready.
module point_angle_sector_filter_core
    import pasf_pkg::*;
#(
    parameter int NUM_SECTORS     = 3,
    parameter int ANGLE_FRAC_BITS = 6
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_point_in                i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_point_out               o_out_word,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic        cfg_we;
    t_sector_cfg sector_cfg;

    logic    [CORDIC_ITERS:0] chain_valid;
    logic    [CORDIC_ITERS:0] chain_ready;
    t_cordic                  chain_cell [CORDIC_ITERS+1];
    logic                     prep_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // sector registers
    for (genvar s = 0; s < SECTOR_SLOTS; s++) begin : g_sector
        if (s < NUM_SECTORS) begin : g_used
            logic [CFG_DATA_BITS-1:0] r_lo;
            logic [CFG_DATA_BITS-1:0] r_hi;
            logic                     r_en;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_lo <= '0;
                    r_hi <= '0;
                    r_en <= 1'b0;
                end else if (cfg_we) begin
                    if (i_cfg_index == REG_START_0 + CFG_IDX_BITS'(2 * s)) begin
                        r_lo <= i_cfg_data;
                    end
                    if (i_cfg_index == REG_END_0 + CFG_IDX_BITS'(2 * s)) begin
                        r_hi <= i_cfg_data;
                    end
                    if (i_cfg_index == REG_ENABLE) begin
                        r_en <= i_cfg_data[s];
                    end
                end
            end

            assign sector_cfg.lo_b[s]   = r_lo;
            assign sector_cfg.hi_b[s]   = r_hi;
            assign sector_cfg.enable[s] = r_en;
        end else begin : g_unused
            assign sector_cfg.lo_b[s]   = '0;
            assign sector_cfg.hi_b[s]   = '0;
            assign sector_cfg.enable[s] = 1'b0;
        end
    end

    // input folding stage
    pasf_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (prep_ready),
        .i_pt    (i_in_word),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_cell  (chain_cell[0])
    );

    assign o_in_stall = !prep_ready;

    // cordic cell chain
    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cell
        pasf_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_cell  (chain_cell[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_cell  (chain_cell[k+1])
        );
    end

    // bearing, sector match and output register
    pasf_sector #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[CORDIC_ITERS]),
        .o_ready (chain_ready[CORDIC_ITERS]),
        .i_cell  (chain_cell[CORDIC_ITERS]),
        .i_cfg   (sector_cfg),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule
